// ===== hdl/wspr_pkg.sv =====
// Shared constants, character maps and the sync vector for the WSPR symbol encoder.
// No dependencies; imported by the encoder top level and its checker.
`default_nettype none

package wspr_pkg;

  localparam int SYMBOL_COUNT = 162;
  localparam int GROUPS       = SYMBOL_COUNT / 3;
  localparam int SYM_AW       = $clog2(SYMBOL_COUNT);
  localparam int GRP_W        = $clog2(GROUPS);

  localparam logic [31:0] POLY_A = 32'hF2D05351;
  localparam logic [31:0] POLY_B = 32'hE4613C47;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Sync bit of channel symbol i sits at SYNC_VEC[i].
  localparam logic [0:SYMBOL_COUNT-1] SYNC_VEC = {
    18'b110000001000111000,
    18'b100101111000000010,
    18'b010100000010110011,
    18'b010001101000011010,
    18'b101010010010110001,
    18'b101010001000001001,
    18'b001110110011010001,
    18'b110000010100110000,
    18'b000110101100011000
  };

  // Digits 0..9, letters 10..35, space 36, anything else 0.
  function automatic logic [5:0] map_alnum(input logic [7:0] c);
    logic [5:0] v;
    v = 6'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 6'(c - CH_ZERO);
    end else if (c >= CH_A && c <= CH_Z) begin
      v = 6'(c - CH_A) + 6'd10;
    end else if (c == CH_SPACE) begin
      v = 6'd36;
    end
    return v;
  endfunction

  function automatic logic [3:0] map_num(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 4'(c - CH_ZERO);
    end
    return v;
  endfunction

  // Letters 0..25, space 26, anything else 0.
  function automatic logic [4:0] map_alpha(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c == CH_SPACE) begin
      v = 5'd26;
    end else if (c >= CH_A && c <= CH_Z) begin
      v = 5'(c - CH_A);
    end
    return v;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/wspr_message_symbol_encoder.sv =====
// WSPR type-1 message encoder top level: packing, K=32 r=1/2 convolutional coder,
// bit-reversal interleaver and symbol readout. Depends on wspr_pkg and wspr_ram.
//
// Usage:
//   Input channel (in_valid / in_stall): one transfer carries one whole beacon
//   message: six callsign characters, four locator characters and a power code.
//   Result channel (out_valid / out_stall): each message yields 54 transfers,
//   each carrying three four-level channel symbols (2*data + sync) plus the
//   group number; out_last_group marks group 53.
//   Steps per message: packing (one constant multiply-add per cycle), then
//   walking all 256 indices of the 8-bit bit-reversal interleaver (one index
//   per cycle, one write into the 162x1 symbol RAM when the index lands below
//   162), then reading three RAM entries per group through the single read port.
//   The block takes one message at a time; in_stall is high from the accept
//   until the last group has been loaded into the output register, so the next
//   message can be accepted while that group still waits to be taken.
//   A stall on the result channel holds the output register and freezes the
//   readout; nothing is lost or repeated.
//   Reset (rst_n low, synchronous) returns to idle and drops any pending result;
//   the symbol RAM needs no clearing since every message rewrites all entries.
`default_nettype none

module wspr_message_symbol_encoder
  import wspr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_call_char1,
  input  wire logic [7:0] in_call_char2,
  input  wire logic [7:0] in_call_char3,
  input  wire logic [7:0] in_call_char4,
  input  wire logic [7:0] in_call_char5,
  input  wire logic [7:0] in_call_char6,
  input  wire logic [7:0] in_loc_char1,
  input  wire logic [7:0] in_loc_char2,
  input  wire logic [7:0] in_loc_char3,
  input  wire logic [7:0] in_loc_char4,
  input  wire logic [5:0] in_power_dbm,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [5:0]      out_group_index,
  output logic [1:0]      out_sym_a,
  output logic [1:0]      out_sym_b,
  output logic [1:0]      out_sym_c,
  output logic            out_last_group
);

  typedef enum logic [1:0] {ST_IDLE, ST_PACK, ST_WALK, ST_READ} state_t;

  state_t            state_r;
  logic [2:0]        pk_step_r;
  logic [7:0]        walk_r;
  logic [GRP_W-1:0]  grp_r;
  logic [SYM_AW-1:0] base_r;
  logic [1:0]        sub_r;

  // mapped message digits
  logic [5:0]  dig_r [6];
  logic [4:0]  l1_r, l2_r;
  logic [3:0]  n1_r, n2_r;
  logic [5:0]  pwr_r;

  logic [27:0] cs_r, cs_nxt;
  logic [14:0] loc_r, loc_nxt;
  logic [21:0] lp;

  logic [31:0] shift_r;
  logic [49:0] msg_r;
  logic        phase_r;
  logic        b0_r, b1_r;

  logic        out_valid_r;
  logic [5:0]  out_grp_r;
  logic [1:0]  out_a_r, out_b_r, out_c_r;
  logic        out_last_r;

  logic [7:0]        rev;
  logic              ram_we, ram_re, ram_rdata, coded;
  logic [SYM_AW-1:0] ram_raddr;
  logic [SYM_AW-1:0] idx_b, idx_c;
  logic              out_load, in_xfer;

  // ---------------------------------------------------------------------------
  // Packing: one constant multiply-add per cycle for each word.
  // ---------------------------------------------------------------------------
  always_comb begin
    case (pk_step_r)
      3'd0:    cs_nxt = 28'(dig_r[0]);
      3'd1:    cs_nxt = 28'(cs_r * 28'd36) + 28'(dig_r[1]);
      3'd2:    cs_nxt = 28'(cs_r * 28'd10) + 28'(dig_r[2]);
      default: cs_nxt = 28'(cs_r * 28'd27) + 28'(dig_r[pk_step_r]);
    endcase
  end

  // Only the low 15 bits of the locator reach the 22-bit word, so work mod 2^15.
  always_comb begin
    case (pk_step_r)
      3'd0:    loc_nxt = 15'd179 - 15'(15'(l1_r) * 15'd10) - 15'(n1_r);
      3'd1:    loc_nxt = 15'(loc_r * 15'd180);
      3'd2:    loc_nxt = loc_r + 15'(15'(l2_r) * 15'd10) + 15'(n2_r);
      default: loc_nxt = loc_r;
    endcase
  end

  // 128*loc + 64 + power; the power field never exceeds 63, so no carry into loc.
  assign lp = {loc_r, 1'b1, pwr_r};

  // ---------------------------------------------------------------------------
  // Encoder and interleaver walk.
  // ---------------------------------------------------------------------------
  assign rev    = rev8(walk_r);
  assign ram_we = (state_r == ST_WALK) && (rev < 8'(SYMBOL_COUNT));
  assign coded  = phase_r ? ^(shift_r & POLY_B) : ^(shift_r & POLY_A);

  // ---------------------------------------------------------------------------
  // Readout: three reads per group through the single read port.
  // ---------------------------------------------------------------------------
  assign ram_re    = (state_r == ST_READ) && (sub_r != 2'd3);
  assign ram_raddr = base_r + SYM_AW'(sub_r);
  assign idx_b     = base_r + SYM_AW'(1);
  assign idx_c     = base_r + SYM_AW'(2);
  assign out_load  = (state_r == ST_READ) && (sub_r == 2'd3) &&
                     (!out_valid_r || !out_stall);
  assign in_xfer   = in_valid && !in_stall;

  wspr_ram #(
    .WIDTH (1),
    .DEPTH (SYMBOL_COUNT)
  ) u_sym_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rev[SYM_AW-1:0]),
    .wdata (coded),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pk_step_r   <= 3'd0;
      walk_r      <= 8'd0;
      grp_r       <= '0;
      base_r      <= '0;
      sub_r       <= 2'd0;
      phase_r     <= 1'b0;
      shift_r     <= 32'd0;
      cs_r        <= 28'd0;
      loc_r       <= 15'd0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the output register once taken, unless a new group loads below
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            dig_r[0]  <= map_alnum(in_call_char1);
            dig_r[1]  <= map_alnum(in_call_char2);
            dig_r[2]  <= 6'(map_num(in_call_char3));
            dig_r[3]  <= 6'(map_alpha(in_call_char4));
            dig_r[4]  <= 6'(map_alpha(in_call_char5));
            dig_r[5]  <= 6'(map_alpha(in_call_char6));
            l1_r      <= map_alpha(in_loc_char1);
            l2_r      <= map_alpha(in_loc_char2);
            n1_r      <= map_num(in_loc_char3);
            n2_r      <= map_num(in_loc_char4);
            pwr_r     <= in_power_dbm;
            pk_step_r <= 3'd0;
            state_r   <= ST_PACK;
          end
        end

        ST_PACK: begin
          cs_r      <= cs_nxt;
          loc_r     <= loc_nxt;
          pk_step_r <= pk_step_r + 3'd1;
          if (pk_step_r == 3'd5) begin
            // push the first message bit; hold the rest MSB first
            shift_r <= {31'd0, cs_nxt[27]};
            msg_r   <= {cs_nxt[26:0], lp, 1'b0};
            phase_r <= 1'b0;
            walk_r  <= 8'd0;
            state_r <= ST_WALK;
          end
        end

        ST_WALK: begin
          if (ram_we) begin
            phase_r <= !phase_r;
            if (phase_r) begin
              // both coded bits used: shift in the next message bit (zero tail)
              shift_r <= {shift_r[30:0], msg_r[49]};
              msg_r   <= {msg_r[48:0], 1'b0};
            end
          end
          walk_r <= walk_r + 8'd1;
          if (walk_r == 8'hFF) begin
            grp_r   <= '0;
            base_r  <= '0;
            sub_r   <= 2'd0;
            state_r <= ST_READ;
          end
        end

        ST_READ: begin
          if (sub_r == 2'd1) begin
            b0_r <= ram_rdata;
          end
          if (sub_r == 2'd2) begin
            b1_r <= ram_rdata;
          end
          if (sub_r != 2'd3) begin
            sub_r <= sub_r + 2'd1;
          end else if (out_load) begin
            out_valid_r <= 1'b1;
            out_grp_r   <= 6'(grp_r);
            out_a_r     <= {b0_r, SYNC_VEC[base_r]};
            out_b_r     <= {b1_r, SYNC_VEC[idx_b]};
            out_c_r     <= {ram_rdata, SYNC_VEC[idx_c]};
            out_last_r  <= (grp_r == GRP_W'(GROUPS - 1));
            sub_r       <= 2'd0;
            grp_r       <= grp_r + GRP_W'(1);
            base_r      <= base_r + SYM_AW'(3);
            if (grp_r == GRP_W'(GROUPS - 1)) begin
              state_r <= ST_IDLE;
            end
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_group_index = out_grp_r;
  assign out_sym_a       = out_a_r;
  assign out_sym_b       = out_b_r;
  assign out_sym_c       = out_c_r;
  assign out_last_group  = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/wspr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wspr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 162,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/wspr_chk.sv =====
// Port-level checker for the WSPR symbol encoder, bound to the top level.
// Depends on wspr_pkg and wspr_message_symbol_encoder.
`default_nettype none

module wspr_chk
  import wspr_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [5:0] out_group_index,
  input wire logic [1:0] out_sym_a,
  input wire logic [1:0] out_sym_b,
  input wire logic [1:0] out_sym_c,
  input wire logic       out_last_group
);

  // a stalled result holds
  ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_group_index) &&
      $stable(out_sym_a) && $stable(out_sym_b) && $stable(out_sym_c))
    else $error("stalled result changed");

  ast_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_group == (out_group_index == 6'(GROUPS - 1))))
    else $error("last_group disagrees with group index");

  ast_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_group_index < 6'(GROUPS)))
    else $error("group index out of range");

  // an accepted message keeps the input side busy
  ast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after transfer");

  ast_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear the channels");

endmodule

bind wspr_message_symbol_encoder wspr_chk u_wspr_chk (.*);

`default_nettype wire

// ===== dv/tb_wspr_message_symbol_encoder.sv =====
// Testbench for wspr_message_symbol_encoder: drives beacon messages, predicts the 54
// symbol groups of each one and checks them in order. Depends on wspr_pkg (hdl/).
`timescale 1ns / 1ps

module tb_wspr_message_symbol_encoder
  import wspr_pkg::*;
();

  // One beacon message as it crosses the input channel.
  typedef struct {
    logic [7:0] call_ch [6];
    logic [7:0] loc_ch [4];
    logic [5:0] power;
  } beacon_msg_t;

  // One transfer on the result channel.
  typedef struct packed {
    logic [5:0] group_index;
    logic [1:0] sym_a;
    logic [1:0] sym_b;
    logic [1:0] sym_c;
    logic       last_group;
  } symbol_group_t;

  // Bytes on either side of every range the character maps care about.
  localparam logic [7:0] BOUNDARY_BYTES [17] = '{
    8'h00, 8'h1F, 8'h20, 8'h21, 8'h2F, 8'h30, 8'h39, 8'h3A, 8'h40,
    8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h80, 8'hFF
  };

  localparam int RANDOM_MESSAGES = 400;

  // Expected symbol groups, oldest first. A message adds 54 groups at once.
  class wspr_symbol_scoreboard;
    symbol_group_t expected_groups[$];
    int unsigned   error_count;

    function new();
      error_count = 0;
    endfunction

    // Digits 0..9, letters 10..35, space 36, anything else 0.
    function int unsigned alnum_code(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
      if (c >= CH_A && c <= CH_Z) return c - CH_A + 10;
      if (c == CH_SPACE) return 36;
      return 0;
    endfunction

    function int unsigned digit_code(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
      return 0;
    endfunction

    // Letters 0..25, space 26, anything else 0.
    function int unsigned letter_code(logic [7:0] c);
      if (c == CH_SPACE) return 26;
      if (c >= CH_A && c <= CH_Z) return c - CH_A;
      return 0;
    endfunction

    function int unsigned pending();
      return expected_groups.size();
    endfunction

    // Pack, encode, interleave and form the symbols of one accepted message.
    function void note_message(beacon_msg_t m);
      logic [31:0]             call_word;
      logic [31:0]             locator;
      logic [31:0]             loc_power;
      logic [80:0]             msg_bits;
      logic [31:0]             enc_state;
      logic [0:SYMBOL_COUNT-1] coded_bits;
      logic [0:SYMBOL_COUNT-1] interleaved;
      logic [7:0]              rev;
      int unsigned             taken;
      symbol_group_t           grp;

      call_word = alnum_code(m.call_ch[0]);
      call_word = 36 * call_word + alnum_code(m.call_ch[1]);
      call_word = 10 * call_word + digit_code(m.call_ch[2]);
      call_word = 27 * call_word + letter_code(m.call_ch[3]);
      call_word = 27 * call_word + letter_code(m.call_ch[4]);
      call_word = 27 * call_word + letter_code(m.call_ch[5]);

      // 32-bit wrap is intended: letters past 'R' or a space push the locator negative.
      locator = (32'd179 - 32'd10 * letter_code(m.loc_ch[0]) - digit_code(m.loc_ch[2]))
                * 32'd180 + 32'd10 * letter_code(m.loc_ch[1]) + digit_code(m.loc_ch[3]);
      loc_power = 32'd128 * locator + 32'd64 + 32'(m.power);

      // 28 callsign bits, 22 locator/power bits, 31 zero tail bits, MSB first.
      msg_bits  = {call_word[27:0], loc_power[21:0], 31'd0};
      enc_state = '0;
      for (int i = 0; i < 81; i++) begin
        enc_state             = {enc_state[30:0], msg_bits[80-i]};
        coded_bits[2*i]       = ^(enc_state & POLY_A);
        coded_bits[2*i+1]     = ^(enc_state & POLY_B);
      end

      // Walk all 256 indices; only reversed indices below 162 take a coded bit.
      taken = 0;
      for (int idx = 0; idx < 256; idx++) begin
        for (int k = 0; k < 8; k++) begin
          rev[k] = idx[7-k];
        end
        if (rev < SYMBOL_COUNT && taken < SYMBOL_COUNT) begin
          interleaved[rev] = coded_bits[taken];
          taken++;
        end
      end

      for (int g = 0; g < GROUPS; g++) begin
        grp.group_index = 6'(g);
        grp.sym_a       = {interleaved[3*g],   SYNC_VEC[3*g]};
        grp.sym_b       = {interleaved[3*g+1], SYNC_VEC[3*g+1]};
        grp.sym_c       = {interleaved[3*g+2], SYNC_VEC[3*g+2]};
        grp.last_group  = (g == GROUPS - 1);
        expected_groups.push_back(grp);
      end
    endfunction

    function void compare_field(string field_name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field_name, want, got);
        error_count++;
      end
    endfunction

    function void check_group(symbol_group_t got);
      symbol_group_t want;
      if (expected_groups.size() == 0) begin
        $display("%0t: group transfer with nothing expected: expected none, actual %0d %0d %0d %0d %0b",
                 $time, got.group_index, got.sym_a, got.sym_b, got.sym_c, got.last_group);
        error_count++;
        return;
      end
      want = expected_groups.pop_front();
      compare_field("group_index", want.group_index, got.group_index);
      compare_field("sym_a", want.sym_a, got.sym_a);
      compare_field("sym_b", want.sym_b, got.sym_b);
      compare_field("sym_c", want.sym_c, got.sym_c);
      compare_field("last_group", want.last_group, got.last_group);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_call_char1;
  logic [7:0] in_call_char2;
  logic [7:0] in_call_char3;
  logic [7:0] in_call_char4;
  logic [7:0] in_call_char5;
  logic [7:0] in_call_char6;
  logic [7:0] in_loc_char1;
  logic [7:0] in_loc_char2;
  logic [7:0] in_loc_char3;
  logic [7:0] in_loc_char4;
  logic [5:0] in_power_dbm;
  logic       out_valid;
  logic       out_stall;
  logic [5:0] out_group_index;
  logic [1:0] out_sym_a;
  logic [1:0] out_sym_b;
  logic [1:0] out_sym_c;
  logic       out_last_group;

  wspr_symbol_scoreboard symbol_board;
  beacon_msg_t           seen_msg;
  // High while both sides run flat out: no input gaps, no result stalls.
  logic                  steady_flow;

  wspr_message_symbol_encoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_call_char1   (in_call_char1),
    .in_call_char2   (in_call_char2),
    .in_call_char3   (in_call_char3),
    .in_call_char4   (in_call_char4),
    .in_call_char5   (in_call_char5),
    .in_call_char6   (in_call_char6),
    .in_loc_char1    (in_loc_char1),
    .in_loc_char2    (in_loc_char2),
    .in_loc_char3    (in_loc_char3),
    .in_loc_char4    (in_loc_char4),
    .in_power_dbm    (in_power_dbm),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_group_index (out_group_index),
    .out_sym_a       (out_sym_a),
    .out_sym_b       (out_sym_b),
    .out_sym_c       (out_sym_c),
    .out_last_group  (out_last_group)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: far beyond the slowest legal run, even with every group held
  // through the longest result stall.
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Monitors sample at the rising edge, before any nonblocking update lands,
  // so they see exactly the values the block saw.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      seen_msg.call_ch[0] = in_call_char1;
      seen_msg.call_ch[1] = in_call_char2;
      seen_msg.call_ch[2] = in_call_char3;
      seen_msg.call_ch[3] = in_call_char4;
      seen_msg.call_ch[4] = in_call_char5;
      seen_msg.call_ch[5] = in_call_char6;
      seen_msg.loc_ch[0]  = in_loc_char1;
      seen_msg.loc_ch[1]  = in_loc_char2;
      seen_msg.loc_ch[2]  = in_loc_char3;
      seen_msg.loc_ch[3]  = in_loc_char4;
      seen_msg.power      = in_power_dbm;
      symbol_board.note_message(seen_msg);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      symbol_board.check_group({out_group_index, out_sym_a, out_sym_b, out_sym_c,
                                out_last_group});
    end
  end

  // Result-side backpressure: mostly open runs, short stalls, now and then a
  // long one. No burst ends where it starts; out_stall changes at most once per edge.
  initial begin
    int unsigned roll;
    int unsigned span;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      roll = $urandom_range(99);
      if (steady_flow || roll < 60) begin
        out_stall <= 1'b0;
        span = steady_flow ? 1 : $urandom_range(1, 16);
      end else if (roll < 95) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        span = $urandom_range(8, 40);
      end
      repeat (span) @(posedge clk);
    end
  end

  // Idle cycles before the next message: mostly none or a few, sometimes many.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (steady_flow || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happens.
  // Drop valid only when a gap follows, so valid never gets two updates in one step.
  task automatic drive_message(input beacon_msg_t m);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_call_char1 <= m.call_ch[0];
    in_call_char2 <= m.call_ch[1];
    in_call_char3 <= m.call_ch[2];
    in_call_char4 <= m.call_ch[3];
    in_call_char5 <= m.call_ch[4];
    in_call_char6 <= m.call_ch[5];
    in_loc_char1  <= m.loc_ch[0];
    in_loc_char2  <= m.loc_ch[1];
    in_loc_char3  <= m.loc_ch[2];
    in_loc_char4  <= m.loc_ch[3];
    in_power_dbm  <= m.power;
    // Hold the payload until the block stops stalling.
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input string call, input string loc, input logic [5:0] power);
    beacon_msg_t m;
    for (int i = 0; i < 6; i++) m.call_ch[i] = call[i];
    for (int i = 0; i < 4; i++) m.loc_ch[i] = loc[i];
    m.power = power;
    drive_message(m);
  endtask

  // Hold the sender until every expected group has come back. The first edge
  // lets the input monitor record a transfer made at the current edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (symbol_board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_alnum();
    int unsigned v;
    v = $urandom_range(36);
    if (v < 10) return 8'(CH_ZERO + v);
    if (v < 36) return 8'(CH_A + v - 10);
    return CH_SPACE;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(CH_ZERO + $urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_letter();
    int unsigned v;
    v = $urandom_range(26);
    if (v == 26) return CH_SPACE;
    return 8'(CH_A + v);
  endfunction

  // Real locator fields run 'A'..'R'; leave some room for the wrapping cases.
  function automatic logic [7:0] pick_field_letter();
    if ($urandom_range(9) < 8) return 8'(CH_A + $urandom_range(17));
    return pick_letter();
  endfunction

  function automatic logic [7:0] pick_noise();
    if ($urandom_range(1) == 1) return BOUNDARY_BYTES[$urandom_range(16)];
    return 8'($urandom);
  endfunction

  // Mostly well-formed beacons, some with a few corrupted characters, some pure noise.
  function automatic beacon_msg_t random_beacon();
    beacon_msg_t m;
    int unsigned kind;
    int unsigned field;
    kind = $urandom_range(99);
    m.call_ch[0] = pick_alnum();
    m.call_ch[1] = pick_alnum();
    m.call_ch[2] = pick_digit();
    m.call_ch[3] = pick_letter();
    m.call_ch[4] = pick_letter();
    m.call_ch[5] = pick_letter();
    m.loc_ch[0]  = pick_field_letter();
    m.loc_ch[1]  = pick_field_letter();
    m.loc_ch[2]  = pick_digit();
    m.loc_ch[3]  = pick_digit();
    m.power      = 6'($urandom);
    if (kind >= 85) begin
      for (int i = 0; i < 6; i++) m.call_ch[i] = 8'($urandom);
      for (int i = 0; i < 4; i++) m.loc_ch[i] = 8'($urandom);
    end else if (kind >= 70) begin
      repeat ($urandom_range(1, 3)) begin
        field = $urandom_range(9);
        if (field < 6) m.call_ch[field] = pick_noise();
        else m.loc_ch[field-6] = pick_noise();
      end
    end
    return m;
  endfunction

  initial begin
    beacon_msg_t m;
    symbol_board = new();
    steady_flow  = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_call_char1 <= '0;
    in_call_char2 <= '0;
    in_call_char3 <= '0;
    in_call_char4 <= '0;
    in_call_char5 <= '0;
    in_call_char6 <= '0;
    in_loc_char1  <= '0;
    in_loc_char2  <= '0;
    in_loc_char3  <= '0;
    in_loc_char4  <= '0;
    in_power_dbm  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: typical calls, the largest values, all-space fields (locator
    // wraps), locator letters past 'R', characters outside their field's set.
    send_text(" K1ABC", "FN42", 6'd37);
    send_text("ZZ9ZZZ", "RR99", 6'd63);
    send_text("009AAA", "AA00", 6'd0);
    send_text("  0   ", "    ", 6'd10);
    send_text("AB5 Z ", "ZZ99", 6'd1);
    send_text("9Z Q5A", "9A Z", 6'd32);
    // Every field at each byte that borders a mapped range.
    foreach (BOUNDARY_BYTES[b]) begin
      for (int i = 0; i < 6; i++) m.call_ch[i] = BOUNDARY_BYTES[b];
      for (int i = 0; i < 4; i++) m.loc_ch[i] = BOUNDARY_BYTES[b];
      m.power = 6'(BOUNDARY_BYTES[b]);
      drive_message(m);
    end
    wait_drained();

    // Random: a stretch at full rate, and one more full drain midway.
    for (int n = 0; n < RANDOM_MESSAGES; n++) begin
      steady_flow = (n >= 120 && n < 160);
      if (n == 250) wait_drained();
      drive_message(random_beacon());
    end
    steady_flow = 1'b0;

    wait_drained();
    // Give a stray extra transfer time to show up.
    repeat (100) @(posedge clk);
    if (symbol_board.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
